/* hdl/wlh_pkg.sv */
`default_nettype none
package wlh_pkg;

  localparam int HIST_BINS = 26;
  localparam int BUCKET_CAP = 24;
  localparam int BUCKET_W = 5;
  localparam logic [63:0] THRESH_RESET = 64'd1000000;

  typedef enum logic [1:0] {
    KIND_WAKE   = 2'd0,
    KIND_SWITCH = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_CALC   = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  typedef struct packed {
    logic [1:0]          kind;
    logic [9:0]          task_id;
    logic [63:0]         timestamp;
    logic [7:0]          priority_req;
    logic [BUCKET_W-1:0] bucket_select;
  } in_beat_t;

  typedef struct packed {
    logic                matched;
    logic [63:0]         latency;
    logic [63:0]         wakeup_time;
    logic                report;
    logic [9:0]          task_out;
    logic [7:0]          priority_out;
    logic [BUCKET_W-1:0] bucket;
    logic [63:0]         bucket_count;
  } out_beat_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] wake_time;
  } tbl_entry_t;

endpackage
`default_nettype wire

/* hdl/wlh_in_if.sv */
`default_nettype none
interface wlh_in_if;
  logic             valid;
  logic             ready;
  wlh_pkg::in_beat_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/wlh_out_if.sv */
`default_nettype none
interface wlh_out_if;
  logic               valid;
  logic               ready;
  wlh_pkg::out_beat_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* hdl/wakeup_latency_histogrammer_unit.sv */
// flow: table read at accept, latency subtract in LOOKUP, histogram read in CALC,
//   write-back of both memories and result beat registered in COMMIT, which waits
//   while out_ch holds an untaken beat; in_ch takes the next item only in IDLE
// reset: threshold goes to 1000000 and the histogram reads as zero at once;
//   a pass over all TASK_SLOTS entries clears the wakeup table, in_ch not ready
`default_nettype none
module wakeup_latency_histogrammer_unit #(
  parameter int TASK_SLOTS = 1024
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wlh_in_if.sink           in_ch,
  wlh_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [63:0] cfg_wdata
);

  localparam int IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int BW = wlh_pkg::BUCKET_W;

  function automatic logic [BW-1:0] lat_to_bin(input logic [63:0] v);
    logic [BW-1:0] b;
    b = '0;
    for (int i = 1; i < wlh_pkg::BUCKET_CAP; i++) begin
      if (v[i]) b = BW'(i);
    end
    if (|v[63:wlh_pkg::BUCKET_CAP]) b = BW'(wlh_pkg::BUCKET_CAP);
    return b;
  endfunction

  wlh_pkg::state_t     state_r, state_nxt;
  logic [IW-1:0]       clr_idx_r;
  logic [63:0]         thr_r;

  wlh_pkg::tbl_entry_t tbl_mem [TASK_SLOTS];
  wlh_pkg::tbl_entry_t tbl_rd_r;
  logic [63:0]         hist_mem [wlh_pkg::HIST_BINS];
  logic [wlh_pkg::HIST_BINS-1:0] hist_vld_r;
  logic [63:0]         hist_rd_r;
  logic                hist_hit_r;

  wlh_pkg::in_beat_t   item_r;
  logic                matched_r;
  logic [63:0]         lat_r;
  logic [63:0]         then_r;
  logic                report_r;
  logic [BW-1:0]       bucket_r;

  logic                out_valid_r;
  wlh_pkg::out_beat_t  out_r;
  wlh_pkg::out_beat_t  out_nxt;

  logic                in_acc;
  logic                commit;
  logic [16:0]         in_task_ext;
  logic [16:0]         item_task_ext;
  logic                item_in_range;
  logic [IW-1:0]       in_idx;
  logic [IW-1:0]       item_idx;
  logic [BW-1:0]       lat_bucket;
  logic [BW-1:0]       hist_addr;
  logic                hist_addr_ok;
  logic [63:0]         hist_old;

  assign in_ch.ready   = (state_r == wlh_pkg::ST_IDLE);
  assign in_acc        = in_ch.valid && in_ch.ready;
  assign out_ch.valid  = out_valid_r;
  assign out_ch.data   = out_r;
  assign commit        = (state_r == wlh_pkg::ST_COMMIT) && (!out_valid_r || out_ch.ready);

  assign in_task_ext   = 17'(in_ch.data.task_id);
  assign item_task_ext = 17'(item_r.task_id);
  assign in_idx        = in_task_ext[IW-1:0];
  assign item_idx      = item_task_ext[IW-1:0];
  assign item_in_range = item_task_ext < 17'(TASK_SLOTS);

  assign lat_bucket    = lat_to_bin(lat_r);
  assign hist_addr     = (item_r.kind == wlh_pkg::KIND_READ) ? item_r.bucket_select : lat_bucket;
  assign hist_addr_ok  = 32'(hist_addr) < 32'(wlh_pkg::HIST_BINS);
  assign hist_old      = hist_hit_r ? hist_rd_r : 64'd0;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wlh_pkg::ST_CLEAR:  if (clr_idx_r == IW'(TASK_SLOTS - 1)) state_nxt = wlh_pkg::ST_IDLE;
      wlh_pkg::ST_IDLE:   if (in_acc) state_nxt = wlh_pkg::ST_LOOKUP;
      wlh_pkg::ST_LOOKUP: state_nxt = wlh_pkg::ST_CALC;
      wlh_pkg::ST_CALC:   state_nxt = wlh_pkg::ST_COMMIT;
      wlh_pkg::ST_COMMIT: if (commit) state_nxt = wlh_pkg::ST_IDLE;
      default:            state_nxt = wlh_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    out_nxt = '0;
    case (item_r.kind)
      wlh_pkg::KIND_SWITCH: begin
        if (matched_r) begin
          out_nxt.matched     = 1'b1;
          out_nxt.latency     = lat_r;
          out_nxt.wakeup_time = then_r;
          out_nxt.report      = report_r;
          out_nxt.bucket      = bucket_r;
          if (report_r) begin
            out_nxt.task_out     = item_r.task_id;
            out_nxt.priority_out = item_r.priority_req;
          end
        end
      end
      wlh_pkg::KIND_READ: begin
        out_nxt.bucket       = item_r.bucket_select;
        out_nxt.bucket_count = hist_old;
      end
      default: out_nxt = '0;
    endcase
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wlh_pkg::ST_CLEAR;
      clr_idx_r   <= '0;
      thr_r       <= wlh_pkg::THRESH_RESET;
      out_valid_r <= 1'b0;
      hist_vld_r  <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == wlh_pkg::ST_CLEAR) clr_idx_r <= clr_idx_r + IW'(1);
      if (cfg_we) thr_r <= cfg_wdata;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (commit && matched_r) hist_vld_r[bucket_r] <= 1'b1;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (in_acc) item_r <= in_ch.data;
    if (state_r == wlh_pkg::ST_LOOKUP) begin
      matched_r <= (item_r.kind == wlh_pkg::KIND_SWITCH) && item_in_range && tbl_rd_r.vld;
      lat_r     <= item_r.timestamp - tbl_rd_r.wake_time;
      then_r    <= tbl_rd_r.wake_time;
    end
    if (state_r == wlh_pkg::ST_CALC) begin
      report_r <= matched_r && (lat_r >= thr_r);
      bucket_r <= lat_bucket;
    end
    if (commit) out_r <= out_nxt;
  end

  // wakeup table
  always_ff @(posedge clk) begin
    if (in_acc) tbl_rd_r <= tbl_mem[in_idx];
    if (state_r == wlh_pkg::ST_CLEAR) begin
      tbl_mem[clr_idx_r] <= '0;
    end else if (commit && item_in_range) begin
      if (item_r.kind == wlh_pkg::KIND_WAKE) begin
        tbl_mem[item_idx] <= '{vld: 1'b1, wake_time: item_r.timestamp};
      end else if (matched_r) begin
        tbl_mem[item_idx] <= '{vld: 1'b0, wake_time: then_r};
      end
    end
  end

  // histogram
  always_ff @(posedge clk) begin
    if (state_r == wlh_pkg::ST_CALC) begin
      hist_hit_r <= hist_addr_ok && hist_vld_r[hist_addr];
      if (hist_addr_ok) hist_rd_r <= hist_mem[hist_addr];
    end
    if (commit && matched_r) hist_mem[bucket_r] <= hist_old + 64'd1;
  end

endmodule
`default_nettype wire

/* verif/wakeup_latency_histogrammer_unit_tb.sv */
`timescale 1ns / 1ps
module wakeup_latency_histogrammer_unit_tb;

  localparam int TASK_SLOTS = 1024;
  localparam int BW = wlh_pkg::BUCKET_W;
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 7;
  localparam int HOLD_CYCLES = 200;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [63:0] cfg_wdata;

  wlh_in_if in_ch();
  wlh_out_if out_ch();

  wakeup_latency_histogrammer_unit #(
    .TASK_SLOTS(TASK_SLOTS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // mirror of the block state
  logic [63:0] slot_time [TASK_SLOTS];
  bit slot_armed [TASK_SLOTS];
  logic [63:0] bin_count [wlh_pkg::HIST_BINS];
  logic [63:0] report_threshold;

  // stimulus side view of which tasks are waiting for dispatch
  bit gen_armed [TASK_SLOTS];
  logic [63:0] gen_stamp [TASK_SLOTS];
  int armed_ids[$];

  wlh_pkg::in_beat_t item_backlog[$];
  wlh_pkg::out_beat_t results_due[$];

  int fail_count = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int hold_left = 0;
  bit hold_done = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic wlh_pkg::in_beat_t make_item(logic [1:0] k, logic [9:0] id,
                                                  logic [63:0] ts, logic [7:0] prio,
                                                  logic [4:0] sel);
    wlh_pkg::in_beat_t b;
    b.kind = k;
    b.task_id = id;
    b.timestamp = ts;
    b.priority_req = prio;
    b.bucket_select = sel;
    return b;
  endfunction

  function automatic wlh_pkg::out_beat_t predict_event(wlh_pkg::in_beat_t b);
    wlh_pkg::out_beat_t r;
    logic [63:0] lat;
    int unsigned bk;
    r = '0;
    case (b.kind)
      wlh_pkg::KIND_WAKE: begin
        slot_time[b.task_id] = b.timestamp;
        slot_armed[b.task_id] = 1'b1;
      end
      wlh_pkg::KIND_SWITCH: begin
        if (slot_armed[b.task_id]) begin
          lat = b.timestamp - slot_time[b.task_id];
          slot_armed[b.task_id] = 1'b0;
          bk = 0;
          for (int i = 1; i <= wlh_pkg::BUCKET_CAP; i++) begin
            if (lat >= (64'd1 << i)) bk = i;
          end
          bin_count[bk] = bin_count[bk] + 64'd1;
          r.matched = 1'b1;
          r.latency = lat;
          r.wakeup_time = slot_time[b.task_id];
          if (lat >= report_threshold) begin
            r.report = 1'b1;
            r.task_out = b.task_id;
            r.priority_out = b.priority_req;
          end
          r.bucket = BW'(bk);
        end
      end
      wlh_pkg::KIND_READ: begin
        r.bucket = b.bucket_select;
        if (b.bucket_select < wlh_pkg::HIST_BINS) r.bucket_count = bin_count[b.bucket_select];
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (fail_count < 100) begin
      $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    end
    fail_count++;
  endtask

  task automatic queue_random_items(int n);
    int r;
    int pick;
    logic [9:0] id;
    logic [63:0] ts;
    logic [7:0] prio;
    logic [4:0] sel;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      id = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 31)) : 10'($urandom);
      ts = rand64();
      prio = 8'($urandom_range(0, 255));
      sel = 5'($urandom_range(0, 31));
      if (r < 40) begin
        if (!gen_armed[id]) armed_ids.push_back(id);
        gen_armed[id] = 1'b1;
        gen_stamp[id] = ts;
        item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, id, ts, prio, sel));
      end else if (r < 80 && armed_ids.size() != 0) begin
        pick = $urandom_range(0, armed_ids.size() - 1);
        id = 10'(armed_ids[pick]);
        armed_ids.delete(pick);
        if (gen_armed[id]) ts = gen_stamp[id] + (rand64() >> $urandom_range(0, 63));
        gen_armed[id] = 1'b0;
        item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, id, ts, prio, sel));
      end else if (r < 90) begin
        gen_armed[id] = 1'b0;
        item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, id, ts, prio, sel));
      end else if (r < 97) begin
        item_backlog.push_back(make_item(wlh_pkg::KIND_READ, id, ts, prio, sel));
      end else begin
        item_backlog.push_back(make_item(KIND_UNUSED, id, ts, prio, sel));
      end
    end
  endtask

  task automatic drain();
    while (item_backlog.size() != 0 || in_ch.valid || results_due.size() != 0) begin
      @(negedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_threshold(logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    report_threshold = value;
  endtask

  // driver
  always @(posedge clk) begin : drive_proc
    bit fire;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        results_due.push_back(predict_event(in_ch.data));
        items_sent <= items_sent + 1;
      end
      if (fire || !in_ch.valid) begin
        if (item_backlog.size() != 0 &&
            ((items_sent >= 400 && items_sent < 800) || $urandom_range(0, 99) >= 24)) begin
          in_ch.data <= item_backlog.pop_front();
          in_ch.valid <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_proc
    wlh_pkg::out_beat_t got;
    wlh_pkg::out_beat_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        beats_seen <= beats_seen + 1;
        if (results_due.size() == 0) begin
          report_mismatch("beat with nothing due, latency", got.latency, 64'd0);
        end else begin
          want = results_due.pop_front();
          if (got.matched !== want.matched)
            report_mismatch("matched", got.matched, want.matched);
          if (got.latency !== want.latency)
            report_mismatch("latency", got.latency, want.latency);
          if (got.wakeup_time !== want.wakeup_time)
            report_mismatch("wakeup_time", got.wakeup_time, want.wakeup_time);
          if (got.report !== want.report)
            report_mismatch("report", got.report, want.report);
          if (got.task_out !== want.task_out)
            report_mismatch("task_out", got.task_out, want.task_out);
          if (got.priority_out !== want.priority_out)
            report_mismatch("priority_out", got.priority_out, want.priority_out);
          if (got.bucket !== want.bucket)
            report_mismatch("bucket", got.bucket, want.bucket);
          if (got.bucket_count !== want.bucket_count)
            report_mismatch("bucket_count", got.bucket_count, want.bucket_count);
        end
      end
      out_ch.ready <= (hold_left == 0) &&
                      ((beats_seen >= 400 && beats_seen < 800) || $urandom_range(0, 99) >= 24);
    end
  end

  // one long receiver hold-off while the sender keeps going
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && beats_seen >= 1200) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  initial begin
    logic [63:0] limits [NUM_PHASES];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    out_ch.ready = 1'b0;
    report_threshold = wlh_pkg::THRESH_RESET;
    for (int i = 0; i < TASK_SLOTS; i++) begin
      slot_armed[i] = 1'b0;
      slot_time[i] = '0;
      gen_armed[i] = 1'b0;
    end
    for (int i = 0; i < wlh_pkg::HIST_BINS; i++) bin_count[i] = '0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed beats under the reset threshold
    item_backlog.push_back(make_item(wlh_pkg::KIND_READ, 10'd0, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd0, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd0, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd1023, '1, 8'd0, 5'd31));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd1023, 64'd0, 8'd139, 5'd31));
    // overwrite, then latency exactly at threshold
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd7, 64'd100, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd7, 64'd200, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd7, 64'd1000200, 8'd255, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd8, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd8, 64'd999999, 8'd77, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd9, 64'd5000, 8'd5, 5'd3));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd7, 64'd9000000, 8'd5, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd10, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd10, 64'd1 << 24, 8'd1, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd11, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd11, '1, 8'd2, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd12, 64'd0, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd12, (64'd1 << 24) - 64'd1,
                                     8'd3, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_WAKE, 10'd13, 64'd5, 8'd0, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_SWITCH, 10'd13, 64'd7, 8'd4, 5'd0));
    item_backlog.push_back(make_item(wlh_pkg::KIND_READ, 10'd0, 64'd0, 8'd0, 5'd24));
    item_backlog.push_back(make_item(wlh_pkg::KIND_READ, 10'd0, 64'd0, 8'd0, 5'd25));
    item_backlog.push_back(make_item(wlh_pkg::KIND_READ, 10'd0, 64'd0, 8'd0, 5'd31));
    item_backlog.push_back(make_item(wlh_pkg::KIND_READ, 10'd0, 64'd0, 8'd0, 5'd26));
    item_backlog.push_back(make_item(KIND_UNUSED, 10'd1023, '1, 8'd255, 5'd31));
    drain();

    limits[0] = 64'd0;
    limits[1] = '1;
    limits[2] = 64'd1;
    limits[3] = 64'd1 << $urandom_range(1, 30);
    limits[4] = rand64() >> $urandom_range(20, 63);
    limits[5] = 64'd1 << 24;
    limits[6] = rand64();
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_threshold(limits[p]);
      queue_random_items(PHASE_ITEMS);
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/wlh_pkg.sv
hdl/wlh_in_if.sv
hdl/wlh_out_if.sv
hdl/wakeup_latency_histogrammer_unit.sv
verif/wakeup_latency_histogrammer_unit_tb.sv
